### hw/rtl/perspective_quad_screen_box_top_defines.svh
// assertion helpers for the screen box block
`ifndef PERSPECTIVE_QUAD_SCREEN_BOX_TOP_DEFINES_SVH
`define PERSPECTIVE_QUAD_SCREEN_BOX_TOP_DEFINES_SVH

`define PQSB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pqsb: same-cycle check failed");

`define PQSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pqsb: next-cycle check failed");

`endif

### hw/rtl/pqsb_pkg.sv
package pqsb_pkg;
	localparam int SCREEN_FRAC_BITS = 8;
	localparam int SCREEN_MAX_X     = 639;
	localparam int SCREEN_MAX_Y     = 447;
	localparam int CENTER_X         = 320;
	localparam int CENTER_Y         = 224;
	localparam int ROT_BITS         = 14;

	localparam int CRD_W  = 20;
	localparam int DIF_W  = CRD_W + 1;
	localparam int ANG_W  = 16;
	localparam int FOC_W  = 10;
	localparam int NEAR_W = 16;
	localparam int PRD_W  = DIF_W + ANG_W;
	localparam int RX_W   = PRD_W + 1;
	localparam int PF_W   = RX_W + FOC_W + 1;
	localparam int NUM_W  = PF_W + SCREEN_FRAC_BITS;
	localparam int QUO_W  = NUM_W + 1;
	localparam int SX_W   = NUM_W + 2;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_CAMERA_X = 3'd0,
		REG_CAMERA_Y = 3'd1,
		REG_CAMERA_Z = 3'd2,
		REG_COS      = 3'd3,
		REG_SIN      = 3'd4,
		REG_FOCAL    = 3'd5,
		REG_NEAR     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic mulf;
		logic div_start;
		logic div_sel;
		logic store_qx;
		logic upd;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic cull;
		logic div_busy;
		logic fin;
		logic emit_ok;
		logic out_full;
	} stat_t;
endpackage

### hw/rtl/pqsb_div.sv
module pqsb_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [pqsb_pkg::NUM_W-1:0] num,
	input  logic signed [pqsb_pkg::RX_W-1:0]  den,
	output logic                             busy,
	output logic signed [pqsb_pkg::QUO_W-1:0] quo
);
	import pqsb_pkg::*;

	logic [RX_W-1:0]  rem_q;
	logic [RX_W-1:0]  den_q;
	logic [NUM_W-1:0] mag_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [RX_W:0]    trial;
	logic             qbit;

	always_comb begin
		trial = {rem_q, mag_q[NUM_W-1]};
		qbit  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		end else if (busy_q) begin
			rem_q <= qbit ? RX_W'(trial - {1'b0, den_q}) : RX_W'(trial);
			mag_q <= {mag_q[NUM_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
endmodule

### hw/rtl/pqsb_dp.sv
`include "perspective_quad_screen_box_top_defines.svh"
module pqsb_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pqsb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pqsb_pkg::CFG_W-1:0]  cfg_data,
	input  logic [87:0]                 s_tdata,
	input  logic                        s_tlast,
	output logic [71:0]                 m_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  pqsb_pkg::cmd_t              cmd,
	output pqsb_pkg::stat_t             stat
);
	import pqsb_pkg::*;

	localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] I32_MIN = 32'sh80000000;
	localparam logic signed [SX_W-1:0] CXS = SX_W'(CENTER_X) <<< SCREEN_FRAC_BITS;
	localparam logic signed [SX_W-1:0] CYS = SX_W'(CENTER_Y) <<< SCREEN_FRAC_BITS;

	logic signed [CRD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [ANG_W-1:0] cos_q, sin_q;
	logic [FOC_W-1:0]        focal_q;
	logic [NEAR_W-1:0]       near_q;

	logic signed [DIF_W-1:0] dx_q, dy_q, dz_q;
	logic [7:0]              red_q, green_q, blue_q;
	logic [3:0]              layer_q;
	logic                    fin_q;
	logic signed [PRD_W-1:0] p_xc_q, p_zs_q, p_zc_q, p_xs_q;
	logic signed [RX_W-1:0]  rx_q, ry_q, rz_q;
	logic signed [PF_W-1:0]  pfx, pfy;
	logic signed [NUM_W-1:0] nx_q, ny_q;
	logic signed [QUO_W-1:0] qx_q, quo;
	logic                    div_busy;
	logic signed [RX_W-1:0]  near_ext;
	logic                    cull;

	logic signed [SX_W-1:0]  sx_full, sy_full;
	logic signed [31:0]      sx, sy;
	logic signed [31:0]      min_x_q, max_x_q, min_y_q, max_y_q;
	logic                    front_q, started_q;
	logic                    emit_ok;
	logic [71:0]             out_q;
	logic                    out_valid_q;
	logic [9:0]              px_l, px_r;
	logic [8:0]              py_t, py_b;

	function automatic logic [9:0] to_pix_x(input logic signed [31:0] s);
		logic [31-SCREEN_FRAC_BITS:0] v;
		v = s[31:SCREEN_FRAC_BITS];
		if (s < 0) return '0;
		if (v > (32-SCREEN_FRAC_BITS)'(SCREEN_MAX_X)) return 10'(SCREEN_MAX_X);
		return v[9:0];
	endfunction

	function automatic logic [8:0] to_pix_y(input logic signed [31:0] s);
		logic [31-SCREEN_FRAC_BITS:0] v;
		v = s[31:SCREEN_FRAC_BITS];
		if (s < 0) return '0;
		if (v > (32-SCREEN_FRAC_BITS)'(SCREEN_MAX_Y)) return 9'(SCREEN_MAX_Y);
		return v[8:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			cos_q   <= ANG_W'(1 << ROT_BITS);
			sin_q   <= '0;
			focal_q <= FOC_W'(200);
			near_q  <= NEAR_W'(26);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAMERA_X: cam_x_q <= cfg_data;
				REG_CAMERA_Y: cam_y_q <= cfg_data;
				REG_CAMERA_Z: cam_z_q <= cfg_data;
				REG_COS:      cos_q   <= cfg_data[ANG_W-1:0];
				REG_SIN:      sin_q   <= cfg_data[ANG_W-1:0];
				REG_FOCAL:    focal_q <= cfg_data[FOC_W-1:0];
				REG_NEAR:     near_q  <= cfg_data[NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign pfx = rx_q * $signed({1'b0, focal_q});
	assign pfy = ry_q * $signed({1'b0, focal_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q    <= DIF_W'($signed(s_tdata[19:0])) - DIF_W'(cam_x_q);
			dy_q    <= DIF_W'($signed(s_tdata[39:20])) - DIF_W'(cam_y_q);
			dz_q    <= DIF_W'($signed(s_tdata[59:40])) - DIF_W'(cam_z_q);
			red_q   <= s_tdata[67:60];
			green_q <= s_tdata[75:68];
			blue_q  <= s_tdata[83:76];
			layer_q <= s_tdata[87:84];
			fin_q   <= s_tlast;
		end
		if (cmd.mul) begin
			p_xc_q <= dx_q * cos_q;
			p_zs_q <= dz_q * sin_q;
			p_zc_q <= dz_q * cos_q;
			p_xs_q <= dx_q * sin_q;
		end
		if (cmd.sum) begin
			rx_q <= RX_W'(p_xc_q) + RX_W'(p_zs_q);
			rz_q <= RX_W'(p_zc_q) - RX_W'(p_xs_q);
			ry_q <= RX_W'(dy_q) <<< ROT_BITS;
		end
		if (cmd.mulf) begin
			nx_q <= NUM_W'(pfx) <<< SCREEN_FRAC_BITS;
			ny_q <= NUM_W'(pfy) <<< SCREEN_FRAC_BITS;
		end
		if (cmd.store_qx) begin
			qx_q <= quo;
		end
	end

	assign near_ext = $signed({{(RX_W-NEAR_W-ROT_BITS){1'b0}}, near_q, {ROT_BITS{1'b0}}});
	assign cull     = (rz_q <= 0) || (rz_q < near_ext);

	pqsb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel ? ny_q : nx_q),
		.den    (rz_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_comb begin
		sx_full = CXS + SX_W'(qx_q);
		sy_full = CYS - SX_W'(quo);
		priority if (sx_full > SX_W'(I32_MAX)) sx = I32_MAX;
		else if (sx_full < SX_W'(I32_MIN)) sx = I32_MIN;
		else sx = sx_full[31:0];
		priority if (sy_full > SX_W'(I32_MAX)) sy = I32_MAX;
		else if (sy_full < SX_W'(I32_MIN)) sy = I32_MIN;
		else sy = sy_full[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= 1'b1;
			started_q <= 1'b0;
		end else if (cmd.fin) begin
			front_q   <= 1'b1;
			started_q <= 1'b0;
		end else if (cmd.upd) begin
			if (cull) begin
				front_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && !cull) begin
			if (!started_q || sx < min_x_q) min_x_q <= sx;
			if (!started_q || sx > max_x_q) max_x_q <= sx;
			if (!started_q || sy < min_y_q) min_y_q <= sy;
			if (!started_q || sy > max_y_q) max_y_q <= sy;
		end
	end

	assign emit_ok = front_q && started_q && (max_x_q > min_x_q) && (max_y_q > min_y_q);
	assign px_l    = to_pix_x(min_x_q);
	assign px_r    = to_pix_x(max_x_q);
	assign py_t    = to_pix_y(min_y_q);
	assign py_b    = to_pix_y(max_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin && emit_ok) begin
			out_q <= {6'b0, blue_q, green_q, red_q, layer_q, py_b, px_r, py_t, px_l};
		end
	end

	assign m_tdata  = out_q;
	assign m_tvalid = out_valid_q;

	assign stat.cull     = cull;
	assign stat.div_busy = div_busy;
	assign stat.fin      = fin_q;
	assign stat.emit_ok  = emit_ok;
	assign stat.out_full = out_valid_q;

	`PQSB_ASSERT_SAME(a_no_overwrite, cmd.fin && emit_ok, !out_valid_q)
	`PQSB_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy)
	`PQSB_ASSERT_NEXT(a_fin_clears, cmd.fin, front_q && !started_q)
endmodule

### hw/rtl/pqsb_ctrl.sv
module pqsb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  pqsb_pkg::stat_t stat,
	output pqsb_pkg::cmd_t  cmd
);
	import pqsb_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MUL  = 11'b00000000010,
		S_SUM  = 11'b00000000100,
		S_MULF = 11'b00000001000,
		S_DXI  = 11'b00000010000,
		S_DIVX = 11'b00000100000,
		S_DYI  = 11'b00001000000,
		S_DIVY = 11'b00010000000,
		S_UPD  = 11'b00100000000,
		S_FIN  = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MULF;
			end
			S_MULF: begin
				if (stat.cull) begin
					state_d = S_UPD;
				end else begin
					cmd.mulf = 1'b1;
					state_d  = S_DXI;
				end
			end
			S_DXI: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVX;
			end
			S_DIVX: begin
				if (!stat.div_busy) state_d = S_DYI;
			end
			S_DYI: begin
				cmd.store_qx  = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_DIVY;
			end
			S_DIVY: begin
				if (!stat.div_busy) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = stat.fin ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				if (!(stat.emit_ok && stat.out_full)) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_FIN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### hw/rtl/perspective_quad_screen_box_top.sv
// A box is valid once its final vertex is accepted and, unless culled, has run two
// 57-step divisions on one shared bit-serial divider and the update and finish states.
// Throughput: one vertex in flight at a time; a culled vertex skips both divisions, and
// the last of a run also passes the finish state; the next is taken on return to idle.
// The result sits in an output register; a stall holds the next last vertex with a box.
// Reset: arst_n asynchronous, active low; resets FSM, config, box flags and output valid.
module perspective_quad_screen_box_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pqsb_pkg::IDX_W-1:0] cfg_index,
	input  logic [pqsb_pkg::CFG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// vertex_x, vertex_y, vertex_z, red, green, blue, layer
	input  logic [87:0]                s_tdata,
	// final_vertex
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// left, top, right, bottom, out_layer, out_red, out_green, out_blue, zero pad
	output logic [71:0]                m_tdata
);
	import pqsb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pqsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pqsb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule
